FILE: hdl/miller_rabin_round_defines.svh
// Assertion macros for the Miller-Rabin round block.
// Used by miller_rabin_round.sv; needs a clk and rst in scope.
`ifndef MILLER_RABIN_ROUND_DEFINES_SVH
`define MILLER_RABIN_ROUND_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MRR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MRR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/mrr_pkg.sv
// Shared types and constants for the Miller-Rabin round block.
// No dependencies.
package mrr_pkg;

  localparam int FIELD_W   = 10;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 8;
  localparam int EXT_W     = 32;

  typedef enum logic [1:0] {
    VERDICT_PRIME     = 2'd0,
    VERDICT_COMPOSITE = 2'd1,
    VERDICT_INVALID   = 2'd2
  } verdict_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SPLIT,
    ST_POW,
    ST_POW_SQ,
    ST_POW_WAIT,
    ST_TEST,
    ST_LOOP,
    ST_LOOP_WAIT,
    ST_OUT
  } state_t;

endpackage

FILE: hdl/miller_rabin_round.sv
// Miller-Rabin round block.
// Input: s_tvalid/s_tready/s_tdata carry a candidate n and a witness a.
// Output: m_tvalid/m_tready/m_tdata carry one verdict per input transfer:
//   0 probable prime, 1 composite, 2 invalid (n < 5, n even, a outside 2..n-2).
// One item is worked at a time; s_tready is high only while the block is idle.
// After the transfer, a check step tests the fields and a split step writes
// n-1 = r*2^s; each modular multiplication then runs on the bit-serial multiplier.
// The exponentiation needs one multiply per set bit of r plus one squaring
// per bit above the lowest, and the final loop up to s-1 squarings; the test and
// output steps close out the item. For NBITS=10 the worst case (n = 1023) is 17
// multiplications; an invalid item goes from the check step straight to output.
// The next item is taken the cycle after the verdict is registered, and the
// single multiplier, shared by the exponentiation and the final loop, bounds how
// often items can be taken.
// A finished verdict sits in an output register; the next item is accepted
// while it waits, and that item's verdict is held back until the register
// frees up, so a stalled receiver loses nothing.
// Reset (rst, synchronous) returns to idle and drops any pending verdict.
// Only the low NBITS bits of each 10-bit field are used.
// Depends on mrr_pkg, mrr_modmul and miller_rabin_round_defines.svh.
`include "miller_rabin_round_defines.svh"

module miller_rabin_round
  import mrr_pkg::*;
#(
  parameter int NBITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [9:0] candidate, [19:10] witness
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // [1:0] verdict
);

  localparam int SW = $clog2(NBITS + 1);

  state_t state, state_next;

  logic [NBITS-1:0] n, a, nm1, r, acc, sq;
  logic [SW-1:0]    s, k;
  logic             mul_is_acc;
  verdict_t         res;
  verdict_t         out_verdict;

  logic [EXT_W-1:0] cand_ext, wit_ext;
  logic             in_xfer, invalid;

  logic             mm_start, mm_done;
  logic [NBITS-1:0] mm_x, mm_y, mm_p;

  assign cand_ext = EXT_W'(s_tdata[FIELD_W-1:0]);
  assign wit_ext  = EXT_W'(s_tdata[2*FIELD_W-1:FIELD_W]);
  assign in_xfer  = s_tvalid && s_tready;

  assign invalid = (n < NBITS'(5)) || !n[0] || (a < NBITS'(2)) ||
                   (a > n - NBITS'(2));

  mrr_modmul #(.NBITS(NBITS)) u_modmul (
    .clk   (clk),
    .rst   (rst),
    .start (mm_start),
    .x     (mm_x),
    .y     (mm_y),
    .m     (n),
    .done  (mm_done),
    .p     (mm_p)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_xfer) state_next = ST_CHECK;
      ST_CHECK:     state_next = invalid ? ST_OUT : ST_SPLIT;
      ST_SPLIT:     if (r[0] || s >= SW'(NBITS)) state_next = ST_POW;
      ST_POW:       state_next = (r == '0) ? ST_TEST : ST_POW_WAIT;
      ST_POW_SQ:    state_next = ST_POW_WAIT;
      ST_POW_WAIT: begin
        if (mm_done) begin
          if (mul_is_acc)
            state_next = (r[NBITS-1:1] == '0) ? ST_POW : ST_POW_SQ;
          else
            state_next = ST_POW;
        end
      end
      ST_TEST:      state_next = (acc == NBITS'(1) || acc == nm1) ? ST_OUT : ST_LOOP;
      ST_LOOP:      state_next = (k < s) ? ST_LOOP_WAIT : ST_OUT;
      ST_LOOP_WAIT: begin
        if (mm_done)
          state_next = (mm_p == nm1 || mm_p == NBITS'(1)) ? ST_OUT : ST_LOOP;
      end
      ST_OUT:       if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready = 1'b0;
    mm_start = 1'b0;
    mm_x     = acc;
    mm_y     = acc;
    unique case (state)
      ST_IDLE:   s_tready = 1'b1;
      ST_POW: begin
        mm_start = (r != '0);
        mm_x     = r[0] ? acc : sq;
        mm_y     = sq;
      end
      ST_POW_SQ: begin
        mm_start = 1'b1;
        mm_x     = sq;
        mm_y     = sq;
      end
      ST_LOOP:   mm_start = (k < s);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          n <= cand_ext[NBITS-1:0];
          a <= wit_ext[NBITS-1:0];
        end
      end
      ST_CHECK: begin
        nm1 <= n - NBITS'(1);
        r   <= n - NBITS'(1);
        s   <= '0;
        res <= VERDICT_INVALID;
      end
      ST_SPLIT: begin
        if (!r[0] && s < SW'(NBITS)) begin
          r <= r >> 1;
          s <= s + 1'b1;
        end else begin
          acc <= NBITS'(1);
          sq  <= a;
        end
      end
      ST_POW: mul_is_acc <= r[0];
      ST_POW_SQ: mul_is_acc <= 1'b0;
      ST_POW_WAIT: begin
        if (mm_done) begin
          if (mul_is_acc) begin
            acc <= mm_p;
            if (r[NBITS-1:1] == '0) r <= '0;
          end else begin
            sq <= mm_p;
            r  <= r >> 1;
          end
        end
      end
      ST_TEST: begin
        k   <= SW'(1);
        res <= VERDICT_PRIME;
        if (acc != NBITS'(1) && acc != nm1) res <= VERDICT_COMPOSITE;
      end
      ST_LOOP_WAIT: begin
        if (mm_done) begin
          acc <= mm_p;
          k   <= k + 1'b1;
          if (mm_p == nm1) res <= VERDICT_PRIME;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!m_tvalid || m_tready)) out_verdict <= res;
  end

  assign m_tdata = OUT_DATA_W'(out_verdict);

  `MRR_ASSERT_IMP(a_done_when_waiting, mm_done, (state == ST_POW_WAIT || state == ST_LOOP_WAIT), "multiplier finished outside a wait state")
  `MRR_ASSERT_NXT(a_accept_to_check, in_xfer, (state == ST_CHECK), "accepted item did not enter the check step")
  `MRR_ASSERT_IMP(a_verdict_code, m_tvalid, (m_tdata[1:0] != 2'd3), "undefined verdict code on output")
  `MRR_ASSERT_IMP(a_acc_reduced, (state == ST_TEST), (acc < n), "power result not reduced modulo candidate")

endmodule

FILE: hdl/mrr_modmul.sv
// Bit-serial modular multiplier: p = x*y mod m, one bit of x per cycle, MSB first.
// Requires x, y < m. Depends on nothing but its parameter.
module mrr_modmul #(
  parameter int NBITS = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NBITS-1:0] x,
  input  logic [NBITS-1:0] y,
  input  logic [NBITS-1:0] m,
  output logic             done,
  output logic [NBITS-1:0] p
);

  localparam int CW = $clog2(NBITS);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [NBITS-1:0] xs;
  logic [NBITS-1:0] yr;
  logic [NBITS-1:0] mr;
  logic [NBITS-1:0] acc;

  logic [NBITS:0] dbl, dbl_red, sum, sum_red;

  always_comb begin
    dbl     = {acc, 1'b0};
    dbl_red = (dbl >= {1'b0, mr}) ? dbl - {1'b0, mr} : dbl;
    sum     = dbl_red + (xs[NBITS-1] ? {1'b0, yr} : '0);
    sum_red = (sum >= {1'b0, mr}) ? sum - {1'b0, mr} : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NBITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs  <= x;
      yr  <= y;
      mr  <= m;
      acc <= '0;
    end else if (busy) begin
      xs  <= {xs[NBITS-2:0], 1'b0};
      acc <= sum_red[NBITS-1:0];
    end
  end

  assign p = acc;

endmodule
